// ===== rtl/ddm_pkg.sv =====
// ----------------------------------------------------------------------------
// ddm_pkg: shared types, request codes and microcode program
// Payload structs, the control word format and the sequencer program
// for the decimal digit multiplier.
// ----------------------------------------------------------------------------
package ddm_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
   localparam logic [1:0] REQ_START       = 2'd2;

   localparam logic [3:0] MAX_DIGIT_VALUE = 4'd9;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] digit;
   } req_item_type;

   typedef struct packed {
      logic [3:0] product_digit;
      logic       last;
      logic       overflow;
   } rsp_item_type;

   // microcode
   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLR_INIT,   // k = 0
      OP_CLR,        // acc[k] = 0, k++
      OP_ROW_INIT,   // i = 0
      OP_ROW_RD,     // read second[n2-1-i], j = 0, carry = 0
      OP_ISSUE,      // read first[n1-1-j], acc[i+j]
      OP_MAC,        // acc[i+j] = sum % 10, carry = sum / 10, j++
      OP_CARRY,      // acc[i+n1] = carry, i++
      OP_SCAN_INIT,  // k = top of accumulator
      OP_ACC_RD,     // read acc[k]
      OP_K_DEC,      // k--
      OP_EMIT,       // present acc digit
      OP_DONE        // clear lengths and overflow, go idle
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_K_NOT_LAST,
      COND_EMPTY,
      COND_J_NOT_LAST,
      COND_I_NOT_LAST,
      COND_SCAN_HIT,
      COND_K_ZERO
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic k_last;
      logic k_zero;
      logic empty;
      logic j_last;
      logic i_last;
      logic acc_nonzero;
   } seq_flags_type;

   // step addresses
   localparam logic [PC_W-1:0] STEP_CLR_INIT  = 4'd0;
   localparam logic [PC_W-1:0] STEP_CLR       = 4'd1;
   localparam logic [PC_W-1:0] STEP_ROW_INIT  = 4'd2;
   localparam logic [PC_W-1:0] STEP_ROW_RD    = 4'd3;
   localparam logic [PC_W-1:0] STEP_ISSUE     = 4'd4;
   localparam logic [PC_W-1:0] STEP_MAC       = 4'd5;
   localparam logic [PC_W-1:0] STEP_CARRY     = 4'd6;
   localparam logic [PC_W-1:0] STEP_SCAN_INIT = 4'd7;
   localparam logic [PC_W-1:0] STEP_SCAN_RD   = 4'd8;
   localparam logic [PC_W-1:0] STEP_SCAN_TST  = 4'd9;
   localparam logic [PC_W-1:0] STEP_SCAN_DEC  = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT_RD   = 4'd11;
   localparam logic [PC_W-1:0] STEP_EMIT      = 4'd12;
   localparam logic [PC_W-1:0] STEP_EMIT_DEC  = 4'd13;
   localparam logic [PC_W-1:0] STEP_DONE      = 4'd14;

   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_DONE, cond: COND_NEVER, target: STEP_DONE};
      case (pc)
         STEP_CLR_INIT:  w = '{OP_CLR_INIT,  COND_NEVER,      STEP_CLR_INIT};
         STEP_CLR:       w = '{OP_CLR,       COND_K_NOT_LAST, STEP_CLR};
         STEP_ROW_INIT:  w = '{OP_ROW_INIT,  COND_EMPTY,      STEP_SCAN_INIT};
         STEP_ROW_RD:    w = '{OP_ROW_RD,    COND_NEVER,      STEP_ROW_RD};
         STEP_ISSUE:     w = '{OP_ISSUE,     COND_NEVER,      STEP_ISSUE};
         STEP_MAC:       w = '{OP_MAC,       COND_J_NOT_LAST, STEP_ISSUE};
         STEP_CARRY:     w = '{OP_CARRY,     COND_I_NOT_LAST, STEP_ROW_RD};
         STEP_SCAN_INIT: w = '{OP_SCAN_INIT, COND_NEVER,      STEP_SCAN_INIT};
         STEP_SCAN_RD:   w = '{OP_ACC_RD,    COND_NEVER,      STEP_SCAN_RD};
         STEP_SCAN_TST:  w = '{OP_NOP,       COND_SCAN_HIT,   STEP_EMIT_RD};
         STEP_SCAN_DEC:  w = '{OP_K_DEC,     COND_ALWAYS,     STEP_SCAN_RD};
         STEP_EMIT_RD:   w = '{OP_ACC_RD,    COND_NEVER,      STEP_EMIT_RD};
         STEP_EMIT:      w = '{OP_EMIT,      COND_K_ZERO,     STEP_DONE};
         STEP_EMIT_DEC:  w = '{OP_K_DEC,     COND_ALWAYS,     STEP_EMIT_RD};
         STEP_DONE:      w = '{OP_DONE,      COND_NEVER,      STEP_DONE};
         default:        w = '{OP_DONE,      COND_NEVER,      STEP_DONE};
      endcase
      return w;
   endfunction

   // quotient by ten for sums up to 99
   function automatic logic [3:0] div10(input logic [6:0] x);
      logic [3:0] q;
      q = '0;
      for (int t = 1; t <= 9; t++) begin
         if (x >= 7'(10 * t)) q = 4'(t);
      end
      return q;
   endfunction

endpackage

// ===== rtl/ddm_sequencer.sv =====
// ----------------------------------------------------------------------------
// ddm_sequencer: microcode step counter
// Fetches one control word per step and resolves conditional jumps.
// ----------------------------------------------------------------------------
module ddm_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   launch,
   input  ddm_pkg::seq_flags_type flags,
   output logic                   active,
   output ddm_pkg::ctrl_word_type ctrl
);
   import ddm_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            active_ff, active_in;
   ctrl_word_type   word;
   logic            take;

   assign word = ucode(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_K_NOT_LAST: take = !flags.k_last;
         COND_EMPTY:      take = flags.empty;
         COND_J_NOT_LAST: take = !flags.j_last;
         COND_I_NOT_LAST: take = !flags.i_last;
         COND_SCAN_HIT:   take = flags.acc_nonzero || flags.k_zero;
         COND_K_ZERO:     take = flags.k_zero;
         default:         take = 1'b0;
      endcase
   end

   always_comb begin
      pc_in     = pc_ff;
      active_in = active_ff;
      if (active_ff) begin
         pc_in = take ? word.target : pc_ff + PC_W'(1);
         if (word.op == OP_DONE) active_in = 1'b0;
      end else if (launch) begin
         pc_in     = STEP_CLR_INIT;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= STEP_CLR_INIT;
         active_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         active_ff <= active_in;
      end
   end

   assign active    = active_ff;
   assign ctrl.op   = active_ff ? word.op : OP_NOP;
   assign ctrl.cond = word.cond;
   assign ctrl.target = word.target;

endmodule

// ===== rtl/decimal_digit_multiplier.sv =====
// ----------------------------------------------------------------------------
// decimal_digit_multiplier: BCD schoolbook multiplier
// Loads two decimal operands digit by digit, multiplies them on request and
// streams the product out most significant digit first.
// ----------------------------------------------------------------------------
// Loads: busy stays low, next transfer may follow at once.
// Start: busy through the accumulator clear, the rows (none if an operand is empty),
//   the leading zero scan, the emit of each product digit and the final clear;
//   the digit loop of the shared multiply-add unit sets the pace.
// Results: one digit at a time, rsp_valid high for one cycle each;
//   the receiver cannot stall. Reset clears lengths, overflow and control;
//   the block clears itself the same way after every start.
module decimal_digit_multiplier #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ddm_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output ddm_pkg::rsp_item_type rsp_data
);
   import ddm_pkg::*;

   localparam int LEN_W     = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int ACC_DEPTH = 2 * MAX_DIGITS;
   localparam int ACC_IDX_W = $clog2(ACC_DEPTH);

   // operand stores and product accumulator
   logic [3:0] first_mem  [MAX_DIGITS];
   logic [3:0] second_mem [MAX_DIGITS];
   logic [3:0] acc_mem    [ACC_DEPTH];

   logic [LEN_W-1:0]     first_len_ff, first_len_in;
   logic [LEN_W-1:0]     second_len_ff, second_len_in;
   logic                 overflow_ff, overflow_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [ACC_IDX_W-1:0] k_ff, k_in;
   logic [3:0]           carry_ff, carry_in;
   logic [3:0]           first_rd_ff, second_rd_ff, acc_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   logic          seq_active;
   logic          launch;
   ctrl_word_type ctrl;
   seq_flags_type flags;

   // input transfer decode
   logic       accept;
   logic [3:0] load_digit;
   logic       load_first, load_second;

   assign accept      = start && !seq_active;
   assign launch      = accept && (req_data.req_type == REQ_START);
   assign load_digit  = (req_data.digit > MAX_DIGIT_VALUE) ? MAX_DIGIT_VALUE
                                                           : req_data.digit;
   assign load_first  = accept && (req_data.req_type == REQ_LOAD_FIRST);
   assign load_second = accept && (req_data.req_type == REQ_LOAD_SECOND);

   logic first_room, second_room;
   assign first_room  = first_len_ff  < LEN_W'(MAX_DIGITS);
   assign second_room = second_len_ff < LEN_W'(MAX_DIGITS);

   // address generation
   logic [LEN_W-1:0]     first_off, second_off;
   logic [IDX_W-1:0]     first_addr, second_addr;
   logic [ACC_IDX_W-1:0] acc_ij, acc_carry_addr;

   assign first_off      = first_len_ff - LEN_W'(1) - LEN_W'(j_ff);
   assign second_off     = second_len_ff - LEN_W'(1) - LEN_W'(i_ff);
   assign first_addr     = first_off[IDX_W-1:0];
   assign second_addr    = second_off[IDX_W-1:0];
   assign acc_ij         = ACC_IDX_W'(i_ff) + ACC_IDX_W'(j_ff);
   assign acc_carry_addr = ACC_IDX_W'(i_ff) + ACC_IDX_W'(first_len_ff);

   // multiply-add unit: digit * digit + accumulator digit + carry (max 99)
   logic [7:0] digit_prod;
   logic [6:0] mac_sum;
   logic [3:0] mac_quot;
   logic [6:0] mac_rem;

   assign digit_prod = second_rd_ff * first_rd_ff;
   assign mac_sum    = digit_prod[6:0] + 7'(acc_rd_ff) + 7'(carry_ff);
   assign mac_quot   = div10(mac_sum);
   assign mac_rem    = mac_sum - 7'({mac_quot, 3'b000}) - 7'({mac_quot, 1'b0});

   // status toward the sequencer
   assign flags.k_last      = k_ff == ACC_IDX_W'(ACC_DEPTH - 1);
   assign flags.k_zero      = k_ff == '0;
   assign flags.empty       = (first_len_ff == '0) || (second_len_ff == '0);
   assign flags.j_last      = LEN_W'(j_ff) == (first_len_ff - LEN_W'(1));
   assign flags.i_last      = LEN_W'(i_ff) == (second_len_ff - LEN_W'(1));
   assign flags.acc_nonzero = acc_rd_ff != '0;

   ddm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .flags  (flags),
      .active (seq_active),
      .ctrl   (ctrl)
   );

   assign busy = seq_active;

   // accumulator write port
   logic                 acc_we;
   logic [ACC_IDX_W-1:0] acc_waddr;
   logic [3:0]           acc_wdata;
   logic [ACC_IDX_W-1:0] acc_raddr;

   always_comb begin
      acc_we    = 1'b0;
      acc_waddr = k_ff;
      acc_wdata = '0;
      case (ctrl.op)
         OP_CLR: begin
            acc_we = 1'b1;
         end
         OP_MAC: begin
            acc_we    = 1'b1;
            acc_waddr = acc_ij;
            acc_wdata = mac_rem[3:0];
         end
         OP_CARRY: begin
            acc_we    = 1'b1;
            acc_waddr = acc_carry_addr;
            acc_wdata = carry_ff;
         end
         default: acc_we = 1'b0;
      endcase
   end

   assign acc_raddr = (ctrl.op == OP_ISSUE) ? acc_ij : k_ff;

   // datapath control
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;

      if (load_first) begin
         if (first_room) first_len_in = first_len_ff + LEN_W'(1);
         else overflow_in = 1'b1;
      end
      if (load_second) begin
         if (second_room) second_len_in = second_len_ff + LEN_W'(1);
         else overflow_in = 1'b1;
      end

      case (ctrl.op)
         OP_CLR_INIT:  k_in = '0;
         OP_CLR:       k_in = k_ff + ACC_IDX_W'(1);
         OP_ROW_INIT:  i_in = '0;
         OP_ROW_RD: begin
            j_in     = '0;
            carry_in = '0;
         end
         OP_MAC: begin
            j_in     = j_ff + IDX_W'(1);
            carry_in = mac_quot;
         end
         OP_CARRY:     i_in = i_ff + IDX_W'(1);
         OP_SCAN_INIT: k_in = ACC_IDX_W'(ACC_DEPTH - 1);
         OP_K_DEC:     k_in = k_ff - ACC_IDX_W'(1);
         OP_EMIT: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.product_digit = acc_rd_ff;
            rsp_data_in.last          = flags.k_zero;
            rsp_data_in.overflow      = overflow_ff;
         end
         OP_DONE: begin
            first_len_in  = '0;
            second_len_in = '0;
            overflow_in   = 1'b0;
         end
         default: k_in = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // loop counters and payload, no reset needed
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      carry_ff    <= carry_in;
      rsp_data_ff <= rsp_data_in;
   end

   // operand stores: one write, one registered read each
   always_ff @(posedge clock) begin
      if (load_first && first_room) first_mem[first_len_ff[IDX_W-1:0]] <= load_digit;
      if (ctrl.op == OP_ISSUE) first_rd_ff <= first_mem[first_addr];
   end

   always_ff @(posedge clock) begin
      if (load_second && second_room) second_mem[second_len_ff[IDX_W-1:0]] <= load_digit;
      if (ctrl.op == OP_ROW_RD) second_rd_ff <= second_mem[second_addr];
   end

   // accumulator: one write, one registered read
   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      if ((ctrl.op == OP_ISSUE) || (ctrl.op == OP_ACC_RD)) acc_rd_ff <= acc_mem[acc_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
